// ===== design/wsrr_pkg.sv =====
// Package for the wheel speed ramp regulator: field widths, mode and register
// codes, and the per-wheel arithmetic shared by the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsrr_pkg;

  // Field widths.
  localparam int RAW_W   = 8;
  localparam int MODE_W  = 3;
  localparam int HALF_W  = 9;
  localparam int TOP_W   = 7;
  localparam int SCALE_W = 16;
  localparam int DRIVE_W = 16;
  localparam int SPEED_W = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [HALF_W-1:0] half_t;
  typedef logic signed [RAW_W-1:0]  target_t;
  typedef logic [MODE_W-1:0]        mode_t;

  // Regulation modes. Codes six and seven behave like the ramp modes.
  localparam mode_t MODE_NONE   = 3'd0;
  localparam mode_t MODE_LINEAR = 3'd1;
  localparam mode_t MODE_CURVE  = 3'd2;
  localparam mode_t MODE_TURN   = 3'd3;
  localparam mode_t MODE_BACK   = 3'd4;
  localparam mode_t MODE_WALL   = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic [CFG_ADDR_W-1:0] CFG_TOP_SPEED   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_SCALE = 1'd1;
  localparam logic [TOP_W-1:0]      TOP_SPEED_RST   = 7'd40;
  localparam logic [SCALE_W-1:0]    DRIVE_SCALE_RST = 16'd256;

  // floor(x / 20) for x below 2^10 as (x * 3277) >> 16.
  localparam logic [11:0] DIV20_MUL = 12'd3277;

  // Target in whole units: the raw byte as two's complement, negated when the
  // wheel runs backward. Negating -128 wraps back to -128 in eight bits.
  function automatic target_t target_of(input logic [RAW_W-1:0] raw, input logic back);
    logic [RAW_W-1:0] v;
    v = back ? (8'd0 - raw) : raw;
    return target_t'(v);
  endfunction

  function automatic logic [HALF_W-1:0] mag_of(input half_t h);
    return h[HALF_W-1] ? (9'd0 - 9'(h)) : 9'(h);
  endfunction

  // Decay toward zero: magnitudes under seven units stop, otherwise the
  // magnitude drops by one tenth rounded up, in whole units.
  function automatic half_t decay(input half_t h);
    logic [8:0]  m;
    logic [9:0]  x;
    logic [21:0] p;
    logic [3:0]  q;
    logic [8:0]  r;
    m = mag_of(h);
    x = {1'b0, m} + 10'd19;
    p = x * DIV20_MUL;
    q = p[19:16];
    r = m - {4'd0, q, 1'b0};
    if (m < 9'd14) begin
      return '0;
    end
    return h[HALF_W-1] ? half_t'(9'd0 - r) : half_t'(r);
  endfunction

  // Clamp of an 11-bit half-unit value to +-2*top.
  function automatic logic signed [10:0] clamp_lim(input logic signed [10:0] v,
                                                   input logic [TOP_W-1:0] top);
    logic signed [10:0] lim;
    lim = $signed({3'b000, top, 1'b0});
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // One ramp step in low, mid and high bands, then clamp to the top speed.
  function automatic half_t ramp(input half_t h, input target_t t,
                                 input logic [TOP_W-1:0] top);
    logic signed [10:0] hh;
    logic signed [10:0] tt;
    logic signed [10:0] n;
    logic [8:0]         m;
    logic [7:0]         ta;
    hh = 11'(h);
    tt = {{2{t[7]}}, t, 1'b0};
    m  = mag_of(h);
    ta = t[7] ? (8'd0 - 8'(t)) : 8'(t);
    n  = hh;
    if (m <= 9'd12) begin
      if (tt > 11'sd14) begin
        n = 11'sd14;
      end else if (tt < -11'sd14) begin
        n = -11'sd14;
      end else begin
        n = tt;
      end
    end else if (m <= 9'd30) begin
      if (tt > hh) begin
        n = hh + ((hh > 11'sd0) ? 11'sd2 : 11'sd1);
      end else if (tt < hh) begin
        n = hh - ((hh < 11'sd0) ? 11'sd2 : 11'sd1);
      end
    end else if (ta <= 8'd10) begin
      if (tt > hh) begin
        n = hh + 11'sd8;
      end else if (tt < hh) begin
        n = hh - 11'sd8;
      end
    end else begin
      n = tt;
    end
    return half_t'(clamp_lim(n, top));
  endfunction

endpackage

`default_nettype wire

// ===== design/wheel_speed_ramp_regulator.sv =====
// Top level of the wheel speed ramp regulator: input handshake, regulation
// state, drive multiply and output register. Depends on wsrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The regulator takes one transaction per clock cycle while in_tready is high
// and returns exactly one result transaction for each, in order. On
// acceptance the regulated half-unit speeds, the latched mode and a stage-one
// copy of the speeds are registered; when the output register is free, the
// clamped stage-one speed is multiplied by drive_scale into the output
// register, which drives out_tvalid. While a finished result waits on
// out_tready, stage one can still take one more input; after that in_tready
// stays low until out_tready returns, and in_tready follows out_tready within
// the same cycle. Speeds are held internally in half units. A change to any
// mode but none first brakes both wheels (at once for back, by a one-tenth
// decay per transaction otherwise) and the new mode is latched only once a
// wheel has stopped; a change to none is latched at once. Configuration
// writes take effect on the next clock edge and should be made while the
// block is idle.
module wheel_speed_ramp_regulator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata, lowest bit up: left_cmd[7:0], right_cmd[15:8],
  // left_backward[16], right_backward[17], mode[20:18], zero pad[23:21].
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [wsrr_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, lowest bit up: left_drive[15:0], right_drive[31:16],
  // left_units[39:32], right_units[47:40].
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [wsrr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [wsrr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [wsrr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wsrr_pkg::*;

  // Configuration registers.
  logic [TOP_W-1:0]   top_speed_r;
  logic [SCALE_W-1:0] drive_scale_r;

  // Regulation state.
  half_t left_h_r,  left_h_nxt;
  half_t right_h_r, right_h_nxt;
  mode_t latched_mode_r, latched_mode_nxt;

  // Stage one: snapshot of the updated speeds for this transaction.
  logic  s1_valid_r;
  half_t s1_left_h_r;
  half_t s1_right_h_r;

  // Stage two: output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic in_fire;
  logic s1_adv;
  logic out_load;

  // Input fields.
  logic [RAW_W-1:0] left_raw;
  logic [RAW_W-1:0] right_raw;
  logic             left_back;
  logic             right_back;
  mode_t            mode;
  target_t          left_t;
  target_t          right_t;
  half_t            left_dec;
  half_t            right_dec;

  assign left_raw   = in_tdata[7:0];
  assign right_raw  = in_tdata[15:8];
  assign left_back  = in_tdata[16];
  assign right_back = in_tdata[17];
  assign mode       = in_tdata[20:18];

  // Handshake: the output stage frees when empty or drained, stage one moves
  // when the output stage can take it, and the input is ready when stage one
  // is empty or moving on.
  assign out_load  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  assign left_t    = target_of(left_raw, left_back);
  assign right_t   = target_of(right_raw, right_back);
  assign left_dec  = decay(left_h_r);
  assign right_dec = decay(right_h_r);

  // Next regulation state for an accepted transaction.
  always_comb begin
    left_h_nxt       = left_h_r;
    right_h_nxt      = right_h_r;
    latched_mode_nxt = latched_mode_r;
    if (mode != MODE_NONE && latched_mode_r != mode) begin
      // Braking toward a new mode.
      if (mode == MODE_BACK) begin
        left_h_nxt  = '0;
        right_h_nxt = '0;
      end else begin
        left_h_nxt  = left_dec;
        right_h_nxt = right_dec;
      end
      if (left_h_nxt == '0 || right_h_nxt == '0) begin
        left_h_nxt       = '0;
        right_h_nxt      = '0;
        latched_mode_nxt = mode;
      end
    end else if (mode == MODE_NONE || mode == MODE_WALL) begin
      // Copy modes follow the targets directly.
      left_h_nxt       = {left_t, 1'b0};
      right_h_nxt      = {right_t, 1'b0};
      latched_mode_nxt = mode;
    end else begin
      left_h_nxt  = ramp(left_h_r, left_t, top_speed_r);
      right_h_nxt = ramp(right_h_r, right_t, top_speed_r);
    end
  end

  // Drive and speed words from the stage-one snapshot.
  logic signed [10:0]  left_hc, right_hc;
  logic signed [16:0]  scale_s;
  logic signed [25:0]  left_prod, right_prod;
  logic signed [25:0]  left_adj, right_adj;
  logic signed [16:0]  left_q, right_q;
  logic signed [15:0]  left_drive, right_drive;
  half_t               left_sp9, right_sp9;

  assign left_hc    = clamp_lim(11'(s1_left_h_r), top_speed_r);
  assign right_hc   = clamp_lim(11'(s1_right_h_r), top_speed_r);
  assign scale_s    = $signed({1'b0, drive_scale_r});
  assign left_prod  = left_hc * scale_s;
  assign right_prod = right_hc * scale_s;

  // Division by 512 truncating toward zero: bias negative products first.
  assign left_adj  = left_prod + (left_prod[25] ? 26'sd511 : 26'sd0);
  assign right_adj = right_prod + (right_prod[25] ? 26'sd511 : 26'sd0);
  assign left_q    = 17'(left_adj >>> 9);
  assign right_q   = 17'(right_adj >>> 9);

  always_comb begin
    if (left_q > 17'sd32767) begin
      left_drive = 16'sh7FFF;
    end else if (left_q < -17'sd32768) begin
      left_drive = 16'sh8000;
    end else begin
      left_drive = 16'(left_q);
    end
    if (right_q > 17'sd32767) begin
      right_drive = 16'sh7FFF;
    end else if (right_q < -17'sd32768) begin
      right_drive = 16'sh8000;
    end else begin
      right_drive = 16'(right_q);
    end
  end

  // Whole-unit speed, truncated toward zero.
  assign left_sp9  = (s1_left_h_r + half_t'({8'd0, s1_left_h_r[HALF_W-1]})) >>> 1;
  assign right_sp9 = (s1_right_h_r + half_t'({8'd0, s1_right_h_r[HALF_W-1]})) >>> 1;

  assign out_data_nxt = {right_sp9[SPEED_W-1:0], left_sp9[SPEED_W-1:0],
                         right_drive, left_drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r    <= TOP_SPEED_RST;
      drive_scale_r  <= DRIVE_SCALE_RST;
      left_h_r       <= '0;
      right_h_r      <= '0;
      latched_mode_r <= MODE_NONE;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_TOP_SPEED:   top_speed_r   <= cfg_wdata[TOP_W-1:0];
          CFG_DRIVE_SCALE: drive_scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        left_h_r       <= left_h_nxt;
        right_h_r      <= right_h_nxt;
        latched_mode_r <= latched_mode_nxt;
        s1_valid_r     <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_left_h_r  <= left_h_nxt;
      s1_right_h_r <= right_h_nxt;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
